// ===== src/sbda_pkg.sv =====
package sbda_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CharWidth  = 6;
    localparam int unsigned NumDigits  = 20;
    localparam int unsigned CountWidth = 5;

    localparam logic [CharWidth-1:0] CharMinus = 6'd45;
    localparam logic [CharWidth-1:0] CharZero  = 6'd48;

    typedef logic [ValueWidth-1:0] t_value;
    typedef logic [3:0]            t_digit;
    typedef logic [CountWidth-1:0] t_count;

    // Number as BCD digits plus sign, passed from converter to serialiser
    typedef struct packed {
        logic                        neg;
        logic [NumDigits-1:0][3:0]   bcd;
        t_count                      nd;
    } t_conv;

endpackage

// ===== src/signed_binary_to_decimal_ascii.sv =====
// Signed 64-bit integer to decimal ASCII text.
// Input channel: i_valid/o_ready with i_value, one integer per item.
// Output channel: o_valid/i_ready with o_char_code and o_last, one
// character per item, most significant first; a negative number starts
// with '-', and o_last marks the final digit.
// The conversion pipeline is Stages register stages of double-dabble,
// each shifting 64/Stages magnitude bits; a number passes through these
// stages, the serialiser's load registers and the output register.
// The serialiser loads a number and then emits one character per cycle
// while the output is not stalled; it takes no new number until it has
// registered the last character, and the pipeline holds further numbers meanwhile.
// A receiver stall holds the current character; the serialiser and
// pipeline stages fill and then hold, so nothing is lost or repeated.
// Reset clears all valid flags; no item is in flight afterwards.
module signed_binary_to_decimal_ascii #(
    parameter int unsigned Stages = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [63:0]             i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sbda_pkg::CharWidth-1:0] o_char_code,
    output logic                           o_last
);
    import sbda_pkg::*;

    logic  cv_valid;
    logic  cv_ready;
    t_conv cv_data;

    sbda_conv #(.Stages(Stages)) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (t_value'(i_value)),
        .o_valid (cv_valid),
        .i_ready (cv_ready),
        .o_conv  (cv_data)
    );

    sbda_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cv_valid),
        .o_ready     (cv_ready),
        .i_conv      (cv_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ===== src/sbda_conv.sv =====
// Pipelined double-dabble: Stages register stages, each handling a slice
// of the magnitude bits.
module sbda_conv #(
    parameter int unsigned Stages = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sbda_pkg::t_value i_value,
    output logic           o_valid,
    input  logic           i_ready,
    output sbda_pkg::t_conv o_conv
);
    import sbda_pkg::*;

    localparam int unsigned BitsPerStage = ValueWidth / Stages;

    typedef struct packed {
        logic                      neg;
        logic [NumDigits-1:0][3:0] bcd;
        t_value                    mag;
    } t_work;

    logic  [Stages-1:0] r_vld;
    t_work              r_stg [Stages];
    t_work              n_stg [Stages];
    logic  [Stages:0]   adv;
    t_work              stg_in;

    // Advance when the stage ahead is empty or moving
    always_comb begin
        adv[Stages] = i_ready || !r_vld[Stages-1];
        for (int s = Stages - 1; s >= 1; s--) begin
            adv[s] = adv[s+1] || !r_vld[s-1];
        end
        adv[0] = adv[1];
    end
    assign o_ready = adv[0];

    // Form the magnitude on entry
    always_comb begin
        stg_in.neg = i_value[ValueWidth-1];
        stg_in.bcd = '0;
        stg_in.mag = i_value[ValueWidth-1] ? (~i_value + 1'b1) : i_value;
    end

    // Shift-add-3 over a slice of bits in each stage
    always_comb begin
        t_work w;
        for (int s = 0; s < Stages; s++) begin
            if (s == 0) begin
                w = stg_in;
            end else begin
                w = r_stg[s-1];
            end
            for (int b = 0; b < BitsPerStage; b++) begin
                for (int d = 0; d < NumDigits; d++) begin
                    if (w.bcd[d] >= 4'd5) begin
                        w.bcd[d] = w.bcd[d] + 4'd3;
                    end
                end
                {w.bcd, w.mag} = {w.bcd, w.mag} << 1;
            end
            n_stg[s] = w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < Stages; s++) begin
                if (adv[s+1]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < Stages; s++) begin
            if (adv[s+1]) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    // Count significant digits (at least one)
    always_comb begin
        o_conv.neg = r_stg[Stages-1].neg;
        o_conv.bcd = r_stg[Stages-1].bcd;
        o_conv.nd  = t_count'(1);
        for (int d = 1; d < NumDigits; d++) begin
            if (r_stg[Stages-1].bcd[d] != 4'd0) begin
                o_conv.nd = t_count'(d + 1);
            end
        end
    end
    assign o_valid = r_vld[Stages-1];

endmodule

// ===== src/sbda_ser.sv =====
// Emit sign and digits one character per cycle while busy and unstalled, registered output.
module sbda_ser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  sbda_pkg::t_conv            i_conv,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sbda_pkg::CharWidth-1:0] o_char_code,
    output logic                       o_last
);
    import sbda_pkg::*;

    logic                      r_busy;
    logic                      r_sign;
    logic [NumDigits-1:0][3:0] r_bcd;
    t_count                    r_idx;
    logic                      r_ov;
    logic [CharWidth-1:0]      r_ch;
    logic                      r_last;
    logic                      out_free;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = !r_busy;

    // Load a number, then step out one character per free output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_busy && out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (!r_busy && i_valid) begin
                r_busy <= 1'b1;
                r_sign <= i_conv.neg;
                r_bcd  <= i_conv.bcd;
                r_idx  <= i_conv.nd - 1'b1;
            end else if (r_busy && out_free) begin
                if (r_sign) begin
                    r_ch   <= CharMinus;
                    r_last <= 1'b0;
                    r_sign <= 1'b0;
                end else begin
                    r_ch   <= CharZero + {2'b00, r_bcd[r_idx]};
                    r_last <= (r_idx == '0);
                    if (r_idx == '0) begin
                        r_busy <= 1'b0;
                    end
                    r_idx <= r_idx - 1'b1;
                end
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_char_code = r_ch;
    assign o_last      = r_last;

endmodule
